// File: rtl/can_sfx_pkg.sv
// Shared constants, codes and handoff types of the CAN signal field extractor.
package can_sfx_pkg;

  localparam int MAX_PAYLOAD_BYTES = 64;
  localparam int VALUE_SCALE       = 1000;
  localparam int FACTOR_FRAC_BITS  = 16;

  localparam int ADDR_W   = $clog2(MAX_PAYLOAD_BYTES);
  localparam int POS_W    = 10;
  localparam int MAX_BITS = 64;

  localparam logic [127:0] ROUND_HALF = (128'd1 << FACTOR_FRAC_BITS) >> 1;
  localparam logic [127:0] MAG_LIMIT  = 128'h2_0000_0000;

  localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

  typedef enum logic {
    REQ_LOAD    = 1'b0,
    REQ_EXTRACT = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic        start;
    logic [63:0] raw;
    logic [6:0]  len;
    logic        sgn;
    logic [31:0] factor;
    logic [31:0] offset;
  } scale_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] value;
    logic        sat;
  } scale_rsp_t;

endpackage

// File: rtl/can_sfx_store.sv
// Payload byte RAM with per-byte valid flags and a registered single-bit read.
module can_sfx_store (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [can_sfx_pkg::ADDR_W-1:0] wr_addr,
  input  logic [7:0]                    wr_data,
  input  logic                          rd_en,
  input  logic [can_sfx_pkg::ADDR_W-1:0] rd_addr,
  input  logic [2:0]                    rd_sel,
  output logic                          rd_bit
);

  logic [7:0] mem [can_sfx_pkg::MAX_PAYLOAD_BYTES];
  logic [can_sfx_pkg::MAX_PAYLOAD_BYTES-1:0] vld;
  logic [7:0] rd_data;
  logic       rd_hit;
  logic [2:0] rd_off;

  // never-written bytes read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_hit  <= vld[rd_addr];
      rd_off  <= rd_sel;
    end
  end

  assign rd_bit = rd_hit & rd_data[rd_off];

endmodule

// File: rtl/can_sfx_scale.sv
// Scaling unit: sign/magnitude, one shared 32x32 multiplier over four passes, round, clamp.
module can_sfx_scale (
  input  logic                    clk,
  input  logic                    rst,
  input  can_sfx_pkg::scale_req_t req,
  output can_sfx_pkg::scale_rsp_t rsp
);

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_FS,
    SC_MUL,
    SC_ACC,
    SC_ROUND,
    SC_FINISH
  } sc_state_t;

  localparam logic signed [35:0] SUM_MAX = 36'sh0_7FFF_FFFF;
  localparam logic signed [35:0] SUM_MIN = 36'shF_8000_0000;

  sc_state_t    state;
  logic [63:0]  mag;
  logic [31:0]  fmag;
  logic [63:0]  fs;
  logic         neg;
  logic [31:0]  offset;
  logic [1:0]   step;
  logic [63:0]  pp;
  logic [6:0]   pp_shift;
  logic         pp_vld;
  logic [127:0] acc;

  logic [6:0]   len_m1;
  logic         sign_bit;
  logic         raw_neg;
  logic [63:0]  ext;
  logic [31:0]  a_chunk;
  logic [31:0]  b_chunk;
  logic [6:0]   step_shift;
  logic [127:0] q;
  logic         over;
  logic signed [35:0] off_x;
  logic signed [35:0] q_x;
  logic signed [35:0] sum;

  assign len_m1   = req.len - 7'd1;
  assign sign_bit = req.raw[len_m1[5:0]];
  assign raw_neg  = req.sgn & sign_bit;
  assign ext      = req.raw | (64'hFFFF_FFFF_FFFF_FFFF << req.len);

  assign a_chunk = step[1] ? mag[63:32] : mag[31:0];
  assign b_chunk = step[0] ? fs[63:32]  : fs[31:0];

  always_comb begin
    unique case (step)
      2'd0:    step_shift = 7'd0;
      2'd1:    step_shift = 7'd32;
      2'd2:    step_shift = 7'd32;
      default: step_shift = 7'd64;
    endcase
  end

  assign q     = acc >> can_sfx_pkg::FACTOR_FRAC_BITS;
  assign over  = q > can_sfx_pkg::MAG_LIMIT;
  assign off_x = {{4{offset[31]}}, offset};
  assign q_x   = {2'b00, q[33:0]};
  assign sum   = neg ? (off_x - q_x) : (off_x + q_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= SC_IDLE;
      rsp.done <= 1'b0;
      pp_vld   <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      pp_vld   <= 1'b0;
      unique case (state)
        SC_IDLE: begin
          if (req.start) begin
            mag    <= raw_neg ? (~ext + 64'd1) : req.raw;
            fmag   <= req.factor[31] ? (~req.factor + 32'd1) : req.factor;
            neg    <= raw_neg ^ req.factor[31];
            offset <= req.offset;
            acc    <= '0;
            step   <= 2'd0;
            state  <= SC_FS;
          end
        end
        SC_FS: begin
          fs    <= 64'(fmag) * 64'(can_sfx_pkg::VALUE_SCALE);
          state <= SC_MUL;
        end
        SC_MUL: begin
          pp       <= 64'(a_chunk) * 64'(b_chunk);
          pp_shift <= step_shift;
          pp_vld   <= 1'b1;
          step     <= step + 2'd1;
          if (step == 2'd3) begin
            state <= SC_ACC;
          end
        end
        SC_ACC: begin
          state <= SC_ROUND;
        end
        SC_ROUND: begin
          acc   <= acc + can_sfx_pkg::ROUND_HALF;
          state <= SC_FINISH;
        end
        SC_FINISH: begin
          rsp.done <= 1'b1;
          if (over) begin
            rsp.sat   <= 1'b1;
            rsp.value <= neg ? can_sfx_pkg::INT32_MIN : can_sfx_pkg::INT32_MAX;
          end else if (sum > SUM_MAX) begin
            rsp.sat   <= 1'b1;
            rsp.value <= can_sfx_pkg::INT32_MAX;
          end else if (sum < SUM_MIN) begin
            rsp.sat   <= 1'b1;
            rsp.value <= can_sfx_pkg::INT32_MIN;
          end else begin
            rsp.sat   <= 1'b0;
            rsp.value <= sum[31:0];
          end
          state <= SC_IDLE;
        end
        default: state <= SC_IDLE;
      endcase
      // partial products are added to the accumulator in the cycle after the multiply
      if (pp_vld) begin
        acc <= acc + (128'(pp) << pp_shift);
      end
    end
  end

endmodule

// File: rtl/can_signal_field_extract.sv
// Top level of the CAN signal field extractor: handshakes, bit collector, output register.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------------
//  req     | in        | req_valid/req_stall | req_type byte_index byte_value payload_len
//          |           |                     | sig_start sig_len big_endian sign_ext
//          |           |                     | factor_q16 offset_milli
//  res     | out       | res_valid/res_stall | ok raw_bits phys_value saturated
//
// A load item returns no result and does not stall the request channel; the next item can follow at once.
// For an extract item, one payload bit is read per cycle from the byte RAM, then the
// scaling unit runs its 32x32 multiplier four times, rounds and clamps. A length error
// skips the bit reads and the scaling unit and goes straight to the output register.
// req_stall is high from acceptance of an extract until its result sits in the output
// register. Reset clears the control state and the byte valid flags (all payload bytes read as zero).
// A stalled result holds in the output register; the block still accepts the next item.
module can_signal_field_extract (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               req_valid,
  output logic               req_stall,
  input  logic               req_type,
  input  logic [5:0]         byte_index,
  input  logic [7:0]         byte_value,
  input  logic [6:0]         payload_len,
  input  logic [8:0]         sig_start,
  input  logic [6:0]         sig_len,
  input  logic               big_endian,
  input  logic               sign_ext,
  input  logic signed [31:0] factor_q16,
  input  logic signed [31:0] offset_milli,
  // result channel
  output logic               res_valid,
  input  logic               res_stall,
  output logic               ok,
  output logic [63:0]        raw_bits,
  output logic signed [31:0] phys_value,
  output logic               saturated
);

  localparam int PW = can_sfx_pkg::POS_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COLLECT,
    ST_SCALE,
    ST_EMIT
  } state_t;

  state_t      state;
  logic [PW-1:0] pos;
  logic [PW-1:0] nbits;
  logic [6:0]  len;
  logic [6:0]  issue_cnt;
  logic [6:0]  take_cnt;
  logic        big;
  logic        sgn;
  logic [31:0] factor;
  logic [31:0] offset;
  logic        err;
  logic        rd_pending;
  logic [63:0] raw;
  logic        pend_ok;
  logic [31:0] pend_value;
  logic        pend_sat;

  logic        accept;
  logic        is_load;
  logic        wr_en;
  logic [6:0]  plen_clamp;
  logic        do_issue;
  logic        in_bounds;
  logic        rd_en;
  logic        rd_bit;
  logic [PW-1:0] pos_next;
  logic        collect_end;
  logic        out_free;

  can_sfx_pkg::scale_req_t sreq;
  can_sfx_pkg::scale_rsp_t srsp;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid & ~req_stall;
  assign is_load   = (req_type == can_sfx_pkg::REQ_LOAD);
  // indices past the store are dropped
  assign wr_en     = accept & is_load &
                     (7'(byte_index) < 7'(can_sfx_pkg::MAX_PAYLOAD_BYTES));
  assign plen_clamp = (payload_len > 7'(can_sfx_pkg::MAX_PAYLOAD_BYTES)) ?
                      7'(can_sfx_pkg::MAX_PAYLOAD_BYTES) : payload_len;

  // bit walker: Intel steps up, Motorola steps down and jumps +15 at bit 0 of a byte
  assign do_issue  = (state == ST_COLLECT) & ~err & (issue_cnt != len);
  assign in_bounds = pos < nbits;
  assign rd_en     = do_issue & in_bounds;
  always_comb begin
    if (!big) begin
      pos_next = pos + PW'(1);
    end else if (pos[2:0] == 3'd0) begin
      pos_next = pos + PW'(15);
    end else begin
      pos_next = pos - PW'(1);
    end
  end

  assign collect_end = (state == ST_COLLECT) & ~rd_pending & (err | (issue_cnt == len));
  assign out_free    = ~res_valid | ~res_stall;

  assign sreq.start  = collect_end & ~err;
  assign sreq.raw    = raw;
  assign sreq.len    = len;
  assign sreq.sgn    = sgn;
  assign sreq.factor = factor;
  assign sreq.offset = offset;

  can_sfx_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (byte_index[can_sfx_pkg::ADDR_W-1:0]),
    .wr_data (byte_value),
    .rd_en   (rd_en),
    .rd_addr (pos[can_sfx_pkg::ADDR_W+2:3]),
    .rd_sel  (pos[2:0]),
    .rd_bit  (rd_bit)
  );

  can_sfx_scale u_scale (
    .clk (clk),
    .rst (rst),
    .req (sreq),
    .rsp (srsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      res_valid  <= 1'b0;
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= rd_en;
      // the emit branch reloads the register itself
      if (res_valid && !res_stall && (state != ST_EMIT)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && !is_load) begin
            nbits     <= {plen_clamp, 3'b000};
            len       <= sig_len;
            big       <= big_endian;
            sgn       <= sign_ext;
            factor    <= factor_q16;
            offset    <= offset_milli;
            pos       <= PW'(sig_start);
            issue_cnt <= '0;
            take_cnt  <= '0;
            raw       <= '0;
            err       <= (sig_len == 7'd0) || (sig_len > 7'(can_sfx_pkg::MAX_BITS));
            state     <= ST_COLLECT;
          end
        end
        ST_COLLECT: begin
          if (do_issue) begin
            if (in_bounds) begin
              pos       <= pos_next;
              issue_cnt <= issue_cnt + 7'd1;
            end else begin
              err <= 1'b1;
            end
          end
          if (rd_pending) begin
            if (big) begin
              raw <= {raw[62:0], rd_bit};
            end else begin
              raw[take_cnt[5:0]] <= rd_bit;
            end
            take_cnt <= take_cnt + 7'd1;
          end
          if (collect_end) begin
            if (err) begin
              pend_ok    <= 1'b0;
              pend_value <= '0;
              pend_sat   <= 1'b0;
              state      <= ST_EMIT;
            end else begin
              state <= ST_SCALE;
            end
          end
        end
        ST_SCALE: begin
          if (srsp.done) begin
            pend_ok    <= 1'b1;
            pend_value <= srsp.value;
            pend_sat   <= srsp.sat;
            state      <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            res_valid  <= 1'b1;
            ok         <= pend_ok;
            raw_bits   <= pend_ok ? raw : 64'd0;
            phys_value <= pend_value;
            saturated  <= pend_sat;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/can_sfx_checker.sv
// Port-level checks of the CAN signal field extractor, bound to the top level.
module can_sfx_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_stall,
  input logic               req_type,
  input logic               res_valid,
  input logic               res_stall,
  input logic               ok,
  input logic [63:0]        raw_bits,
  input logic signed [31:0] phys_value,
  input logic               saturated
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(ok) && $stable(raw_bits) &&
      $stable(phys_value) && $stable(saturated))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !ok |-> raw_bits == 64'd0 && phys_value == 32'sd0 && !saturated)
    else $error("failed extract carries nonzero fields");

  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    res_valid && saturated |-> ok &&
      (phys_value == can_sfx_pkg::INT32_MAX || phys_value == can_sfx_pkg::INT32_MIN))
    else $error("saturated value not on an int32 rail");

  a_extract_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req_type == can_sfx_pkg::REQ_EXTRACT |=> req_stall)
    else $error("extract item did not make the block busy");

  a_load_single: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req_type == can_sfx_pkg::REQ_LOAD |=> !req_stall)
    else $error("load item took more than one cycle");

endmodule

bind can_signal_field_extract can_sfx_checker u_can_sfx_checker (.*);
